// File: hdl/multicore_lockup_monitor_assert.svh
// assertion macros used by the lockup monitor controller
`ifndef MULTICORE_LOCKUP_MONITOR_ASSERT_SVH
`define MULTICORE_LOCKUP_MONITOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mlm_pkg.sv
// shared types and constants of the multicore lockup monitor
package mlm_pkg;

  localparam int NUM_CORES = 16;
  localparam int CORE_W    = $clog2(NUM_CORES);
  localparam int MASK_BITS = 16;
  localparam int TIME_W    = 32;
  localparam int THR_W     = 31;
  localparam int STALE_W   = 4;
  localparam logic [STALE_W-1:0] STALE_MAX = '1;

  // input word layout, lowest field first
  localparam int IN_CORE_LO   = 0;
  localparam int IN_NOW_LO    = IN_CORE_LO + 4;
  localparam int IN_ELIG_BIT  = IN_NOW_LO + TIME_W;
  localparam int IN_BUSY_BIT  = IN_ELIG_BIT + 1;
  localparam int IN_ONLINE_LO = IN_BUSY_BIT + 1;
  localparam int IN_SKIP_LO   = IN_ONLINE_LO + MASK_BITS;
  localparam int IN_USED_W    = IN_SKIP_LO + MASK_BITS;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // output word layout, lowest field first
  localparam int OUT_CORE_LO  = 0;
  localparam int OUT_TIME_LO  = OUT_CORE_LO + 4;
  localparam int OUT_USED_W   = OUT_TIME_LO + TIME_W;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ACT_HEARTBEAT = 2'd0,
    ACT_SCHED_RAN = 2'd1,
    ACT_MONITOR   = 2'd2,
    ACT_START     = 2'd3
  } action_e;

  typedef enum logic {
    KIND_SOFT = 1'b0,
    KIND_HARD = 1'b1
  } lockup_kind_e;

  typedef enum logic [1:0] {
    CFG_SOFT_THRESHOLD = 2'd0,
    CFG_STALE_LIMIT    = 2'd1,
    CFG_MONITOR_ENABLE = 2'd2
  } cfg_idx_e;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [THR_W-1:0]   SOFT_THR_RST  = THR_W'(2000);
  localparam logic [STALE_W-1:0] STALE_LIM_RST = STALE_W'(6);

  typedef struct packed {
    logic [THR_W-1:0]   soft_threshold;
    logic [STALE_W-1:0] stale_limit;
    logic               monitor_enable;
  } cfg_t;

  // per-core record held in the state memory
  typedef struct packed {
    logic [TIME_W-1:0]  beat_count;
    logic [TIME_W-1:0]  last_beat;
    logic [STALE_W-1:0] stale_count;
    logic               hard_reported;
    logic [TIME_W-1:0]  sched_stamp;
    logic               stamp_armed;
  } core_entry_t;

  localparam int ENTRY_W = $bits(core_entry_t);

  // request from the controller to the state store
  typedef struct packed {
    logic              rd_en;
    logic [CORE_W-1:0] rd_addr;
    logic              wr_en;
    logic [CORE_W-1:0] wr_addr;
    core_entry_t       wr_data;
    logic              clear_all;
    logic [TIME_W-1:0] base_stamp;
  } store_req_t;

endpackage

// File: hdl/multicore_lockup_monitor.sv
// top level of the multicore lockup monitor
//
// Input stream (s_axis): one word per action. tuser carries the action
// (heartbeat tick, scheduler ran, monitor pass, start); tdata carries core,
// now, eligibility, offline-busy and the online and skip masks.
// Output stream (m_axis): one word per lockup report, tuser is the kind
// (soft or hard), tdata holds core and time, tlast marks the final report
// of the action that caused it.
// Per-core records live in a 16-entry ram with registered read data; each
// heartbeat, scheduler-ran and taken monitor word is a read-modify-write of
// that ram. A monitor pass walks all NUM_CORES entries through the single
// read port, one core entry per cycle unless a full output stalls the walk;
// start and ignored words need no ram access. A found report enters a
// pending slot and waits there until the next report of the action is found
// or the flush state moves it, as the final one, into the output register.
// Reset clears all records at once through per-entry valid bits and loads
// the register defaults; start clears them the same way but keeps the registers.
// A stalled receiver holds the output register; the walk pauses when a new
// report is found while both the pending slot and the output register are full.
// Configuration writes are taken any cycle and should land while idle.
module multicore_lockup_monitor import mlm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // action stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // core[3:0], now[35:4], core_eligible[36], offline_busy[37],
  // online_mask[53:38], skip_mask[69:54], zero pad[71:70]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // action[1:0]
  input  logic [1:0]             s_axis_tuser_i,
  // report stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // report_core[3:0], report_time[35:4], zero pad[39:36]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // lockup_kind[0]
  output logic                   m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  cfg_t        cfg_q;
  store_req_t  store_req;
  core_entry_t store_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.soft_threshold <= SOFT_THR_RST;
      cfg_q.stale_limit    <= STALE_LIM_RST;
      cfg_q.monitor_enable <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SOFT_THRESHOLD: cfg_q.soft_threshold <= cfg_wdata_i[THR_W-1:0];
        CFG_STALE_LIMIT:    cfg_q.stale_limit    <= cfg_wdata_i[STALE_W-1:0];
        CFG_MONITOR_ENABLE: cfg_q.monitor_enable <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  mlm_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (store_req),
    .rd_entry_o (store_rdata)
  );

  mlm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_tvalid_i    (s_axis_tvalid_i),
    .s_tready_o    (s_axis_tready_o),
    .s_tdata_i     (s_axis_tdata_i),
    .s_tuser_i     (s_axis_tuser_i),
    .m_tvalid_o    (m_axis_tvalid_o),
    .m_tready_i    (m_axis_tready_i),
    .m_tdata_o     (m_axis_tdata_o),
    .m_tuser_o     (m_axis_tuser_o),
    .m_tlast_o     (m_axis_tlast_o),
    .store_req_o   (store_req),
    .store_rdata_i (store_rdata)
  );

endmodule

// File: hdl/mlm_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module mlm_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// File: hdl/mlm_store.sv
// per-core state store: ram plus valid bits and start-time defaults
module mlm_store import mlm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  store_req_t  req_i,
  output core_entry_t rd_entry_o
);

  logic [ENTRY_W-1:0]   ram_rdata;
  logic [NUM_CORES-1:0] valid_q;
  logic                 rd_valid_q;
  logic [TIME_W-1:0]    base_stamp_q;
  logic                 base_armed_q;
  core_entry_t          base_entry;

  mlm_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (NUM_CORES)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (req_i.wr_en),
    .wr_addr_i (req_i.wr_addr),
    .wr_data_i (req_i.wr_data),
    .rd_en_i   (req_i.rd_en),
    .rd_addr_i (req_i.rd_addr),
    .rd_data_o (ram_rdata)
  );

  // valid bits and the stamp that unwritten entries carry since the last start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      rd_valid_q   <= 1'b0;
      base_stamp_q <= '0;
      base_armed_q <= 1'b0;
    end else begin
      if (req_i.clear_all) begin
        valid_q      <= '0;
        base_stamp_q <= req_i.base_stamp;
        base_armed_q <= 1'b1;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  // an entry never written since start reads as the default record
  always_comb begin
    base_entry             = '0;
    base_entry.sched_stamp = base_stamp_q;
    base_entry.stamp_armed = base_armed_q;
    rd_entry_o = rd_valid_q ? core_entry_t'(ram_rdata) : base_entry;
  end

endmodule

// File: hdl/mlm_ctrl.sv
// item sequencer: read-modify-write of core records and report queueing
module mlm_ctrl import mlm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [1:0]             s_tuser_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0] m_tdata_o,
  output logic                   m_tuser_o,
  output logic                   m_tlast_o,
  output store_req_t             store_req_o,
  input  core_entry_t            store_rdata_i
);

`include "multicore_lockup_monitor_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FLUSH
  } state_e;

  state_e            state_q;

  // latched item
  action_e           act_q;
  logic [CORE_W-1:0] idx_q;
  logic [TIME_W-1:0] now_q;
  logic              elig_q;
  logic              busy_q;
  logic [MASK_BITS-1:0] online_q;
  logic [MASK_BITS-1:0] skip_q;

  // report waiting for its successor (decides the last flag)
  logic              pend_valid_q;
  logic [CORE_W-1:0] pend_core_q;
  lockup_kind_e      pend_kind_q;
  logic [TIME_W-1:0] pend_time_q;

  // output register
  logic              out_valid_q;
  logic [CORE_W-1:0] out_core_q;
  lockup_kind_e      out_kind_q;
  logic [TIME_W-1:0] out_time_q;
  logic              out_last_q;

  // input field view
  action_e           in_act;
  logic [CORE_W-1:0] in_core;
  logic [TIME_W-1:0] in_now;
  logic              in_busy;
  logic              accept;
  logic              core_ok;

  // evaluation
  core_entry_t       new_ent;
  logic              report;
  lockup_kind_e      rep_kind;
  logic [TIME_W-1:0] diff;
  logic              late;
  logic [STALE_W-1:0] stale_inc;
  logic              slot_free;
  logic              stall;
  logic              last_core;
  logic              out_load;

  assign in_act  = action_e'(s_tuser_i);
  assign in_core = s_tdata_i[IN_CORE_LO +: CORE_W];
  assign in_now  = s_tdata_i[IN_NOW_LO +: TIME_W];
  assign in_busy = s_tdata_i[IN_BUSY_BIT];
  assign core_ok = (32'(in_core) < NUM_CORES);

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign slot_free  = !out_valid_q || m_tready_i;
  assign last_core  = (idx_q == CORE_W'(NUM_CORES - 1));

  // new record and report decision for the entry on the store read data
  always_comb begin
    new_ent   = store_rdata_i;
    report    = 1'b0;
    rep_kind  = KIND_SOFT;
    diff      = now_q - (store_rdata_i.sched_stamp + TIME_W'(cfg_i.soft_threshold));
    late      = (diff != '0) && !diff[TIME_W-1];
    stale_inc = (store_rdata_i.stale_count == STALE_MAX) ? STALE_MAX
                : store_rdata_i.stale_count + STALE_W'(1);
    case (act_q)
      ACT_HEARTBEAT: begin
        new_ent.beat_count = store_rdata_i.beat_count + TIME_W'(1);
        if (store_rdata_i.stamp_armed && late && elig_q && !busy_q) begin
          report              = 1'b1;
          rep_kind            = KIND_SOFT;
          new_ent.stamp_armed = 1'b0;
        end
      end
      ACT_SCHED_RAN: begin
        new_ent.sched_stamp = now_q;
        new_ent.stamp_armed = 1'b1;
      end
      ACT_MONITOR: begin
        if (online_q[idx_q] && !skip_q[idx_q] && !store_rdata_i.hard_reported) begin
          if (store_rdata_i.beat_count == store_rdata_i.last_beat) begin
            new_ent.stale_count = stale_inc;
            if (stale_inc >= cfg_i.stale_limit) begin
              new_ent.hard_reported = 1'b1;
              report                = 1'b1;
              rep_kind              = KIND_HARD;
            end
          end else begin
            new_ent.stale_count = '0;
            new_ent.last_beat   = store_rdata_i.beat_count;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // a new report needs the pending one moved out first
  assign stall = (state_q == ST_EVAL) && report && pend_valid_q && !slot_free;

  // the output register takes a report this cycle
  assign out_load = ((state_q == ST_EVAL) && !stall && report && pend_valid_q) ||
                    ((state_q == ST_FLUSH) && pend_valid_q && slot_free);

  // store requests
  always_comb begin
    store_req_o            = '0;
    store_req_o.wr_data    = new_ent;
    store_req_o.wr_addr    = idx_q;
    store_req_o.base_stamp = in_now;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_act)
            ACT_HEARTBEAT, ACT_SCHED_RAN: begin
              store_req_o.rd_en   = core_ok;
              store_req_o.rd_addr = in_core;
            end
            ACT_MONITOR: begin
              store_req_o.rd_en   = cfg_i.monitor_enable && !in_busy;
              store_req_o.rd_addr = '0;
            end
            default: begin
              store_req_o.clear_all = 1'b1;
            end
          endcase
        end
      end
      ST_EVAL: begin
        if (!stall) begin
          store_req_o.wr_en   = 1'b1;
          store_req_o.rd_en   = (act_q == ACT_MONITOR) && !last_core;
          store_req_o.rd_addr = idx_q + CORE_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // state, item latch, pending report and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (m_tready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            act_q    <= in_act;
            now_q    <= in_now;
            elig_q   <= s_tdata_i[IN_ELIG_BIT];
            busy_q   <= in_busy;
            online_q <= s_tdata_i[IN_ONLINE_LO +: MASK_BITS];
            skip_q   <= s_tdata_i[IN_SKIP_LO +: MASK_BITS];
            case (in_act)
              ACT_HEARTBEAT, ACT_SCHED_RAN: begin
                idx_q <= in_core;
                if (core_ok) begin
                  state_q <= ST_EVAL;
                end
              end
              ACT_MONITOR: begin
                idx_q <= '0;
                if (cfg_i.monitor_enable && !in_busy) begin
                  state_q <= ST_EVAL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_EVAL: begin
          if (!stall) begin
            if (report) begin
              if (pend_valid_q) begin
                out_valid_q <= 1'b1;
                out_core_q  <= pend_core_q;
                out_kind_q  <= pend_kind_q;
                out_time_q  <= pend_time_q;
                out_last_q  <= 1'b0;
              end
              pend_valid_q <= 1'b1;
              pend_core_q  <= idx_q;
              pend_kind_q  <= rep_kind;
              pend_time_q  <= now_q;
            end
            if ((act_q == ACT_MONITOR) && !last_core) begin
              idx_q <= idx_q + CORE_W'(1);
            end else begin
              state_q <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid_q) begin
            state_q <= ST_IDLE;
          end else if (slot_free) begin
            out_valid_q  <= 1'b1;
            out_core_q   <= pend_core_q;
            out_kind_q   <= pend_kind_q;
            out_time_q   <= pend_time_q;
            out_last_q   <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // output word
  always_comb begin
    m_tdata_o = '0;
    m_tdata_o[OUT_CORE_LO +: CORE_W] = out_core_q;
    m_tdata_o[OUT_TIME_LO +: TIME_W] = out_time_q;
  end
  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

  // checks
  `MLM_ASSERT_NOW(a_idle_no_pending, clk_i, rst_ni, state_q == ST_IDLE, !pend_valid_q,
    "report still pending while taking a new word")
  `MLM_ASSERT_NOW(a_rmw_no_overlap, clk_i, rst_ni, store_req_o.rd_en && store_req_o.wr_en,
    store_req_o.rd_addr != store_req_o.wr_addr, "read and write hit the same core entry")
  `MLM_ASSERT_NOW(a_pending_from_eval, clk_i, rst_ni, $rose(pend_valid_q),
    $past(state_q) == ST_EVAL, "pending report appeared outside evaluation")
  `MLM_ASSERT_NEXT(a_flush_empty_idle, clk_i, rst_ni, (state_q == ST_FLUSH) && !pend_valid_q,
    state_q == ST_IDLE, "empty flush did not return to idle")

endmodule

// File: tb/tb_top.sv
// self-checking testbench of the multicore lockup monitor
`timescale 1ns / 1ps

module tb_top import mlm_pkg::*;;

  localparam int MAX_CYCLES    = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20_000;
  localparam int PHASE_WORDS   = 60;

  typedef struct {
    logic [CORE_W-1:0] core;
    lockup_kind_e      kind;
    logic [TIME_W-1:0] at;
    logic              last;
  } lockup_report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i     = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // core, now, core_eligible, offline_busy, online_mask, skip_mask, zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  // action
  logic [1:0]             s_axis_tuser_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // report_core, report_time, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  // lockup_kind
  logic                   m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  // predicted watchdog state and registers
  logic [THR_W-1:0]   soft_thr;
  logic [STALE_W-1:0] stale_lim;
  logic               mon_en;
  logic [TIME_W-1:0]  hb_count     [NUM_CORES];
  logic [TIME_W-1:0]  hb_baseline  [NUM_CORES];
  logic [STALE_W-1:0] stale_passes [NUM_CORES];
  logic               hard_flagged [NUM_CORES];
  logic [TIME_W-1:0]  sched_time   [NUM_CORES];
  logic               sched_armed  [NUM_CORES];

  lockup_report_t pending_reports[$];
  int  mismatches = 0;
  int  cycle_cnt  = 0;
  bit  tx_gaps_on   = 1'b1;
  bit  rx_stalls_on = 1'b1;

  multicore_lockup_monitor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  // state after reset
  function automatic void clear_model();
    soft_thr  = SOFT_THR_RST;
    stale_lim = STALE_LIM_RST;
    mon_en    = 1'b0;
    for (int i = 0; i < NUM_CORES; i++) begin
      hb_count[i]     = '0;
      hb_baseline[i]  = '0;
      stale_passes[i] = '0;
      hard_flagged[i] = 1'b0;
      sched_time[i]   = '0;
      sched_armed[i]  = 1'b0;
    end
  endfunction

  // expected lockup reports of one accepted action word
  function automatic void predict_lockups(action_e act, logic [CORE_W-1:0] core,
                                          logic [TIME_W-1:0] now, logic elig, logic busy,
                                          logic [MASK_BITS-1:0] online,
                                          logic [MASK_BITS-1:0] skip);
    lockup_report_t found[$];
    logic [TIME_W-1:0] slack;
    case (act)
      ACT_HEARTBEAT: begin
        hb_count[core] = hb_count[core] + 1;
        slack = now - (sched_time[core] + {1'b0, soft_thr});
        if (sched_armed[core] && $signed(slack) > 0 && elig && !busy) begin
          found.push_back('{core, KIND_SOFT, now, 1'b0});
          sched_armed[core] = 1'b0;
        end
      end
      ACT_SCHED_RAN: begin
        sched_time[core]  = now;
        sched_armed[core] = 1'b1;
      end
      ACT_MONITOR: begin
        if (mon_en && !busy) begin
          for (int i = 0; i < NUM_CORES; i++) begin
            if (!online[i] || skip[i] || hard_flagged[i]) continue;
            if (hb_count[i] == hb_baseline[i]) begin
              if (stale_passes[i] != STALE_MAX) stale_passes[i]++;
              if (stale_passes[i] >= stale_lim) begin
                hard_flagged[i] = 1'b1;
                found.push_back('{CORE_W'(i), KIND_HARD, now, 1'b0});
              end
            end else begin
              stale_passes[i] = '0;
              hb_baseline[i]  = hb_count[i];
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < NUM_CORES; i++) begin
          hb_count[i]     = '0;
          hb_baseline[i]  = '0;
          stale_passes[i] = '0;
          hard_flagged[i] = 1'b0;
          sched_time[i]   = now;
          sched_armed[i]  = 1'b1;
        end
      end
    endcase
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[k]) pending_reports.push_back(found[k]);
  endfunction

  // register write, only while the block is idle
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SOFT_THRESHOLD: soft_thr  = val[THR_W-1:0];
      CFG_STALE_LIMIT:    stale_lim = val[STALE_W-1:0];
      default:            mon_en    = val[0];
    endcase
  endtask

  // send one action word and predict its reports once accepted
  task automatic send_word(action_e act, logic [CORE_W-1:0] core, logic [TIME_W-1:0] now,
                           logic elig, logic busy, logic [MASK_BITS-1:0] online,
                           logic [MASK_BITS-1:0] skip);
    logic [IN_TDATA_W-1:0] word;
    int gap;
    word = '0;
    word[IN_CORE_LO +: CORE_W]      = core;
    word[IN_NOW_LO +: TIME_W]       = now;
    word[IN_ELIG_BIT]               = elig;
    word[IN_BUSY_BIT]               = busy;
    word[IN_ONLINE_LO +: MASK_BITS] = online;
    word[IN_SKIP_LO +: MASK_BITS]   = skip;
    gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    s_axis_tuser_i  <= act;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_lockups(act, core, now, elig, busy, online, skip);
  endtask

  // stop sending, wait for every expected report, then let the block settle
  task automatic wait_for_reports(int settle);
    int waited;
    waited = 0;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_reports.size() != 0) begin
      report_mismatch($sformatf("%0d expected reports never came", pending_reports.size()));
      pending_reports.delete();
    end
    repeat (settle) @(posedge clk_i);
  endtask

  // report receiver with random stalls
  initial begin
    int gap;
    forever begin
      gap = rx_stalls_on ? $urandom_range(0, 15) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // compare each report word with the oldest expected one
  always @(posedge clk_i) begin
    lockup_report_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report core %0d kind %0d",
                                  m_axis_tdata_o[OUT_CORE_LO +: CORE_W], m_axis_tuser_o));
      end else begin
        want = pending_reports.pop_front();
        if (m_axis_tdata_o[OUT_CORE_LO +: CORE_W] !== want.core)
          report_mismatch($sformatf("report_core %0d, expected %0d",
                                    m_axis_tdata_o[OUT_CORE_LO +: CORE_W], want.core));
        if (m_axis_tuser_o !== want.kind)
          report_mismatch($sformatf("lockup_kind %0d, expected %0d core %0d",
                                    m_axis_tuser_o, want.kind, want.core));
        if (m_axis_tdata_o[OUT_TIME_LO +: TIME_W] !== want.at)
          report_mismatch($sformatf("report_time %h, expected %h core %0d",
                                    m_axis_tdata_o[OUT_TIME_LO +: TIME_W], want.at, want.core));
        if (m_axis_tlast_o !== want.last)
          report_mismatch($sformatf("tlast %0d, expected %0d core %0d",
                                    m_axis_tlast_o, want.last, want.core));
      end
    end
  end

  // reset register values, unarmed stamps, gating of soft reports
  task automatic test_default_registers();
    send_word(ACT_HEARTBEAT, 4'd0, 32'd50, 1'b1, 1'b0, 16'hFFFF, 16'h0000);
    send_word(ACT_START, 4'd9, 32'd100, 1'b0, 1'b0, 16'h0000, 16'hFFFF);
    send_word(ACT_HEARTBEAT, 4'd0, 32'd2101, 1'b1, 1'b0, 16'h0000, 16'h0000);
    send_word(ACT_HEARTBEAT, 4'd1, 32'd2100, 1'b1, 1'b0, 16'h0000, 16'h0000);
    send_word(ACT_HEARTBEAT, 4'd2, 32'd3000, 1'b0, 1'b0, 16'hFFFF, 16'h0000);
    send_word(ACT_HEARTBEAT, 4'd2, 32'd3000, 1'b1, 1'b1, 16'hFFFF, 16'h0000);
    send_word(ACT_HEARTBEAT, 4'd2, 32'd3001, 1'b1, 1'b0, 16'hFFFF, 16'h0000);
    // monitor disabled after reset
    send_word(ACT_MONITOR, 4'd0, 32'd3002, 1'b1, 1'b0, 16'hFFFF, 16'h0000);
    wait_for_reports(SETTLE_CYCLES);
  endtask

  // threshold extremes and time wrap
  task automatic test_soft_lockup_edges();
    write_reg(CFG_SOFT_THRESHOLD, 31'd1);
    send_word(ACT_SCHED_RAN, 4'd3, 32'hFFFF_FFFF, 1'b0, 1'b1, 16'h0000, 16'h0000);
    send_word(ACT_HEARTBEAT, 4'd3, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 16'h0000);
    send_word(ACT_HEARTBEAT, 4'd3, 32'h0000_0001, 1'b1, 1'b0, 16'h0000, 16'h0000);
    send_word(ACT_HEARTBEAT, 4'd3, 32'h0000_0005, 1'b1, 1'b0, 16'h0000, 16'h0000);
    wait_for_reports(SETTLE_CYCLES);
    write_reg(CFG_SOFT_THRESHOLD, 31'h7FFF_FFFF);
    send_word(ACT_SCHED_RAN, 4'd15, 32'h0000_0000, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF);
    send_word(ACT_HEARTBEAT, 4'd15, 32'h8000_0000, 1'b1, 1'b0, 16'h0000, 16'h0000);
    // difference reads as most negative
    send_word(ACT_SCHED_RAN, 4'd14, 32'h0000_0010, 1'b1, 1'b0, 16'h0000, 16'h0000);
    send_word(ACT_HEARTBEAT, 4'd14, 32'h0000_000F, 1'b1, 1'b0, 16'h0000, 16'h0000);
    wait_for_reports(SETTLE_CYCLES);
  endtask

  // hard lockups: busy pass, full sixteen-report pass, masks and stale reset
  task automatic test_hard_lockup_walk();
    write_reg(CFG_MONITOR_ENABLE, 31'd1);
    write_reg(CFG_STALE_LIMIT, 31'd1);
    send_word(ACT_START, 4'd0, 32'h0000_1000, 1'b1, 1'b0, 16'h0000, 16'h0000);
    send_word(ACT_MONITOR, 4'd0, 32'h0000_1001, 1'b1, 1'b1, 16'hFFFF, 16'h0000);
    send_word(ACT_MONITOR, 4'd0, 32'h0000_1002, 1'b1, 1'b0, 16'hFFFF, 16'h0000);
    send_word(ACT_MONITOR, 4'd0, 32'h0000_1003, 1'b1, 1'b0, 16'hFFFF, 16'h0000);
    wait_for_reports(SETTLE_CYCLES);
    write_reg(CFG_STALE_LIMIT, 31'd2);
    send_word(ACT_START, 4'd0, 32'h0000_2000, 1'b1, 1'b0, 16'h0000, 16'h0000);
    send_word(ACT_HEARTBEAT, 4'd1, 32'h0000_2001, 1'b1, 1'b0, 16'h0000, 16'h0000);
    send_word(ACT_MONITOR, 4'd0, 32'h0000_2002, 1'b1, 1'b0, 16'h7FFE, 16'h8001);
    send_word(ACT_MONITOR, 4'd0, 32'h0000_2003, 1'b1, 1'b0, 16'h7FFE, 16'h0000);
    send_word(ACT_MONITOR, 4'd0, 32'h0000_2004, 1'b1, 1'b0, 16'hFFFF, 16'h0000);
    wait_for_reports(SETTLE_CYCLES);
  endtask

  // one random word: mostly well-formed traffic, some noise
  task automatic send_random_word(ref logic [TIME_W-1:0] t_now);
    action_e act;
    int pick;
    logic [CORE_W-1:0] core;
    logic elig, busy;
    logic [MASK_BITS-1:0] online, skip;
    t_now += $urandom_range(0, 40);
    if ($urandom_range(0, 99) < 8) begin
      act = action_e'($urandom_range(0, 3));
      send_word(act, CORE_W'($urandom), $urandom, 1'($urandom), 1'($urandom),
                MASK_BITS'($urandom), MASK_BITS'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      act  = pick < 45 ? ACT_HEARTBEAT : pick < 65 ? ACT_SCHED_RAN :
             pick < 96 ? ACT_MONITOR : ACT_START;
      // upper cores beat rarely so they go stale
      core   = ($urandom_range(0, 3) == 0) ? CORE_W'($urandom_range(0, 15))
                                           : CORE_W'($urandom_range(0, 7));
      elig   = $urandom_range(0, 9) != 0;
      busy   = $urandom_range(0, 11) == 0;
      online = ~MASK_BITS'($urandom & $urandom & $urandom);
      skip   = MASK_BITS'($urandom & $urandom & $urandom);
      send_word(act, core, t_now, elig, busy, online, skip);
    end
  endtask

  // random traffic under several register settings
  task automatic test_random_traffic();
    logic [TIME_W-1:0] t_now;
    logic [THR_W-1:0]  thr_set [4];
    logic [3:0]        lim_set [4];
    logic              en_set  [4];
    thr_set = '{31'd1, 31'h7FFF_FFFF, THR_W'($urandom_range(16, 400)), SOFT_THR_RST};
    lim_set = '{4'd1, 4'd15, 4'($urandom_range(2, 6)), STALE_LIM_RST};
    en_set  = '{1'b1, 1'b1, 1'b1, 1'b0};
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_SOFT_THRESHOLD, thr_set[p]);
      write_reg(CFG_STALE_LIMIT, 31'(lim_set[p]));
      write_reg(CFG_MONITOR_ENABLE, 31'(en_set[p]));
      t_now = $urandom;
      send_word(ACT_START, CORE_W'($urandom), t_now, 1'b1, 1'b0, 16'hFFFF, 16'h0000);
      for (int n = 1; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 19) == 0) tx_gaps_on = !tx_gaps_on;
        if ($urandom_range(0, 19) == 0) rx_stalls_on = !rx_stalls_on;
        // hold the sender until the report stream has caught up
        if (n == PHASE_WORDS / 2) wait_for_reports(0);
        send_random_word(t_now);
      end
      wait_for_reports(SETTLE_CYCLES);
    end
  endtask

  // test sequence
  initial begin
    clear_model();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_default_registers();
    test_soft_lockup_edges();
    test_hard_lockup_walk();
    test_random_traffic();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
